// ----- rtl/lwm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency window monitor package
// Shared sizes, register indexes and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lwm_pkg;

  // Number of samples held per channel.
  localparam int WINDOW = 5;

  localparam int DATA_W  = 32;
  localparam int TIME_W  = 32;
  localparam int IVL_W   = 16;
  localparam int FILL_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W   = DATA_W + FILL_W;
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int CFG_A_W = 2;

  localparam logic [DATA_W-1:0] READ_LIMIT_RST   = DATA_W'(100);
  localparam logic [DATA_W-1:0] UPDATE_LIMIT_RST = DATA_W'(500);
  localparam logic [IVL_W-1:0]  INTERVAL_RST     = IVL_W'(300);

  // Configuration register indexes.
  typedef enum logic [CFG_A_W-1:0] {
    CFG_READ_LIMIT   = 2'd0,
    CFG_UPDATE_LIMIT = 2'd1,
    CFG_INTERVAL     = 2'd2
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic push;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_last;
    logic div_last;
  } status_t;

endpackage

// ----- rtl/lwm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency window monitor datapath
// Configuration registers, per-channel sample rings, the serial window sum,
// the restoring divider and the alarm timing.
// ----------------------------------------------------------------------------
module lwm_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  lwm_pkg::cmd_t                      cmd,
  output lwm_pkg::status_t                   status,
  input  logic                               cfg_we,
  input  logic [lwm_pkg::CFG_A_W-1:0]        cfg_index,
  input  logic [lwm_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               kind,
  input  logic [lwm_pkg::TIME_W-1:0]         start_ms,
  input  logic [lwm_pkg::TIME_W-1:0]         end_ms,
  input  logic [lwm_pkg::TIME_W-1:0]         now_s,
  output logic [lwm_pkg::DATA_W-1:0]         delay_ms,
  output logic [lwm_pkg::DATA_W-1:0]         average_ms,
  output logic                               slow,
  output logic                               alarm
);

  logic [lwm_pkg::DATA_W-1:0] read_limit;
  logic [lwm_pkg::DATA_W-1:0] update_limit;
  logic [lwm_pkg::IVL_W-1:0]  interval;

  logic [lwm_pkg::DATA_W-1:0] ring [2][lwm_pkg::WINDOW];
  logic [lwm_pkg::FILL_W-1:0] fill [2];
  logic [lwm_pkg::SLOT_W-1:0] slot [2];
  logic [lwm_pkg::TIME_W-1:0] last_alarm;

  logic                       kind_r;
  logic [lwm_pkg::DATA_W-1:0] delay_r;
  logic [lwm_pkg::TIME_W-1:0] now_r;
  logic                       slow_r;
  logic                       alarm_r;

  logic [lwm_pkg::SLOT_W-1:0] idx;
  logic [lwm_pkg::SUM_W-1:0]  acc;
  logic [lwm_pkg::SUM_W-1:0]  quot;
  logic [lwm_pkg::FILL_W-1:0] rem;
  logic [lwm_pkg::DCNT_W-1:0] dcnt;

  logic [lwm_pkg::DATA_W-1:0] limit_sel;
  logic                       slow_now;
  logic                       due;
  logic [lwm_pkg::TIME_W:0]   due_time;
  logic [lwm_pkg::FILL_W:0]   rem_sh;
  logic                       rem_ge;
  logic [lwm_pkg::FILL_W-1:0] fill_cur;

  assign fill_cur  = fill[kind_r];
  assign limit_sel = kind_r ? update_limit : read_limit;
  assign slow_now  = delay_r > limit_sel;
  assign due_time  = {1'b0, last_alarm} + (lwm_pkg::TIME_W + 1)'(interval);
  assign due       = (last_alarm == '0) || ({1'b0, now_r} >= due_time);
  assign rem_sh    = {rem, quot[lwm_pkg::SUM_W-1]};
  assign rem_ge    = rem_sh >= {1'b0, fill_cur};

  assign status.sum_last = ((lwm_pkg::FILL_W)'(idx) == fill_cur - 1'b1);
  assign status.div_last = (dcnt == lwm_pkg::DCNT_W'(lwm_pkg::SUM_W - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_limit   <= lwm_pkg::READ_LIMIT_RST;
      update_limit <= lwm_pkg::UPDATE_LIMIT_RST;
      interval     <= lwm_pkg::INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lwm_pkg::CFG_READ_LIMIT:   read_limit   <= cfg_data;
        lwm_pkg::CFG_UPDATE_LIMIT: update_limit <= cfg_data;
        lwm_pkg::CFG_INTERVAL:     interval     <= cfg_data[lwm_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // Channel bookkeeping and alarm time.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill[0]    <= '0;
      fill[1]    <= '0;
      slot[0]    <= '0;
      slot[1]    <= '0;
      last_alarm <= '0;
    end else if (cmd.push) begin
      if (slot[kind_r] == lwm_pkg::SLOT_W'(lwm_pkg::WINDOW - 1)) begin
        slot[kind_r] <= '0;
      end else begin
        slot[kind_r] <= slot[kind_r] + 1'b1;
      end
      if (fill[kind_r] != lwm_pkg::FILL_W'(lwm_pkg::WINDOW)) begin
        fill[kind_r] <= fill[kind_r] + 1'b1;
      end
      if (slow_now && due) begin
        last_alarm <= now_r;
      end
    end
  end

  // Payload: input capture, ring storage, sum, divider and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind;
      delay_r <= end_ms - start_ms;
      now_r   <= now_s;
    end
    if (cmd.push) begin
      ring[kind_r][slot[kind_r]] <= delay_r;
      slow_r  <= slow_now;
      alarm_r <= slow_now && due;
      idx     <= '0;
      acc     <= '0;
    end
    if (cmd.sum_step) begin
      acc <= acc + lwm_pkg::SUM_W'(ring[kind_r][idx]);
      idx <= idx + 1'b1;
    end
    if (cmd.div_init) begin
      quot <= acc;
      rem  <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      quot <= {quot[lwm_pkg::SUM_W-2:0], rem_ge};
      rem  <= rem_ge ? lwm_pkg::FILL_W'(rem_sh - {1'b0, fill_cur})
                     : rem_sh[lwm_pkg::FILL_W-1:0];
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.out_load) begin
      delay_ms   <= delay_r;
      average_ms <= quot[lwm_pkg::DATA_W-1:0];
      slow       <= slow_r;
      alarm      <= alarm_r;
    end
  end

endmodule

// ----- rtl/lwm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency window monitor controller
// Sequences one item through load, ring push, window sum and division, and
// owns the handshake on both channels.
// ----------------------------------------------------------------------------
module lwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lwm_pkg::cmd_t     cmd,
  input  lwm_pkg::status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SUM,
    S_DINIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) begin
          state_next = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/latency_window_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency window monitor
// Two-channel operation latency monitor with windowed average and a
// rate-limited slow-operation alarm.
// ----------------------------------------------------------------------------
// Each item names a channel (read or update), the start and end millisecond
// stamps of an operation and the current time in seconds. The block reports
// the delay (end minus start, modulo 2^32), the integer mean of the last
// WINDOW delays held for that channel including this one, whether the delay
// exceeds the channel's limit, and whether this item raised an alarm. An
// alarm is raised for a slow item when none has been raised yet or when the
// alarm interval has elapsed since the last one; the alarm time is shared
// by both channels, and an alarm stored at time zero counts as never raised.
// Items are handled one at a time. The window sum runs over the samples
// held for the channel (1 to WINDOW) and is SUM_W bits wide, 35 bits for a
// window of five. The sum reads one ring entry per cycle, and the restoring
// divider produces one quotient bit per cycle. The next item is taken in
// the cycle after the result has been loaded into the output register,
// even while that result is still stalled. Configuration registers are to
// be written by the user only while the block is idle; the block itself
// does not enforce this. Writes to an unused index are ignored.
// ----------------------------------------------------------------------------
module latency_window_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lwm_pkg::CFG_A_W-1:0]   cfg_index,
  input  logic [lwm_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [lwm_pkg::TIME_W-1:0]    start_ms,
  input  logic [lwm_pkg::TIME_W-1:0]    end_ms,
  input  logic [lwm_pkg::TIME_W-1:0]    now_s,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lwm_pkg::DATA_W-1:0]    delay_ms,
  output logic [lwm_pkg::DATA_W-1:0]    average_ms,
  output logic                          slow,
  output logic                          alarm
);

  // Command and status bundles between the sequencer and the datapath.
  lwm_pkg::cmd_t    cmd;
  lwm_pkg::status_t status;

  // The controller owns both handshakes and steps the datapath through the
  // push, sum and divide phases of each item.
  lwm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the registers, rings, alarm time and output register.
  lwm_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .kind       (kind),
    .start_ms   (start_ms),
    .end_ms     (end_ms),
    .now_s      (now_s),
    .delay_ms   (delay_ms),
    .average_ms (average_ms),
    .slow       (slow),
    .alarm      (alarm)
  );

endmodule
